[rtl/tsp_pkg.sv]
package tsp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam int MS_WIDTH   = 42;
   localparam int FRAC_WIDTH = 10;

   typedef struct packed {
      logic [7:0] char_code;
   } tsp_req_type;

   typedef struct packed {
      logic signed [MS_WIDTH-1:0] time_ms;
      logic                       valid_res;
   } tsp_rsp_type;

   // Totals of one finished string, handed from the scanner to the scaler.
   typedef struct packed {
      logic                  valid;
      logic                  ok;
      logic                  negative;
      logic [FRAC_WIDTH-1:0] fraction_ms;
   } tsp_total_type;

endpackage

[rtl/tsp_stream_if.sv]
interface tsp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tsp_scan.sv]
module tsp_scan #(
   parameter int SECONDS_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          char_valid,
   input  logic [7:0]                    char_code,
   output logic                          char_take,
   input  logic                          total_pop,
   output tsp_pkg::tsp_total_type        total,
   output logic [SECONDS_WIDTH-2:0]      total_seconds
);

   localparam int W = SECONDS_WIDTH;

   localparam logic [1:0] PHASE_INT  = 2'd0;
   localparam logic [1:0] PHASE_FRAC = 2'd1;
   localparam logic [1:0] PHASE_ERR  = 2'd2;

   logic                          first_ff, first_in;
   logic                          neg_ff, neg_in;
   logic [1:0]                    phase_ff, phase_in;
   logic [W-2:0]                  sec_ff, sec_in;
   logic [W-2:0]                  run_ff, run_in;
   logic [1:0]                    colons_ff, colons_in;
   logic [tsp_pkg::FRAC_WIDTH-1:0] frac_ff, frac_in;
   logic [1:0]                    fdig_ff, fdig_in;

   tsp_pkg::tsp_total_type total_ff, total_in;
   logic [W-2:0]           tsec_ff, tsec_in;

   logic                   is_digit;
   logic                   is_term;
   logic                   in_play;
   logic [W-1:0]           fold_sum;
   logic                   fold_ovf;
   logic [W+2:0]           run_x10;
   logic                   run_ovf;
   logic [W+4:0]           sec_x60;
   logic                   sec60_ovf;
   logic [tsp_pkg::FRAC_WIDTH-1:0] frac_x10;
   logic [tsp_pkg::FRAC_WIDTH-1:0] frac_scaled;

   assign is_term  = (char_code == tsp_pkg::CHAR_NUL);
   assign is_digit = (char_code >= tsp_pkg::CHAR_ZERO) && (char_code <= tsp_pkg::CHAR_NINE);
   assign in_play  = (phase_ff == PHASE_INT) || (phase_ff == PHASE_FRAC);

   // A terminator waits until the totals slot is free; other characters never stall.
   assign char_take = char_valid && (!is_term || !total_ff.valid || total_pop);

   // Both operands stay below 2^(W-1), so the top bit of the sum flags overflow.
   assign fold_sum = {1'b0, sec_ff} + {1'b0, run_ff};
   assign fold_ovf = fold_sum[W-1];

   assign run_x10 = ({4'b0, run_ff} << 3) + ({4'b0, run_ff} << 1)
                  + (W+3)'(char_code[3:0]);
   assign run_ovf = |run_x10[W+2:W-1];

   assign sec_x60 = ({6'b0, fold_sum[W-2:0]} << 6) - ({6'b0, fold_sum[W-2:0]} << 2);
   assign sec60_ovf = |sec_x60[W+4:W-1];

   assign frac_x10 = (frac_ff << 3) + (frac_ff << 1) + tsp_pkg::FRAC_WIDTH'(char_code[3:0]);

   always_comb begin
      unique case (fdig_ff)
         2'd1:    frac_scaled = (frac_ff << 6) + (frac_ff << 5) + (frac_ff << 2);
         2'd2:    frac_scaled = (frac_ff << 3) + (frac_ff << 1);
         default: frac_scaled = frac_ff;
      endcase
   end

   always_comb begin
      first_in  = first_ff;
      neg_in    = neg_ff;
      phase_in  = phase_ff;
      sec_in    = sec_ff;
      run_in    = run_ff;
      colons_in = colons_ff;
      frac_in   = frac_ff;
      fdig_in   = fdig_ff;
      total_in  = total_ff;
      tsec_in   = tsec_ff;

      if (total_pop) begin
         total_in.valid = 1'b0;
      end

      if (char_take) begin
         first_in = 1'b0;
         if (is_term) begin
            total_in.valid       = 1'b1;
            total_in.ok          = in_play && !fold_ovf;
            total_in.negative    = neg_ff;
            total_in.fraction_ms = frac_scaled;
            tsec_in              = fold_sum[W-2:0];
            first_in  = 1'b1;
            neg_in    = 1'b0;
            phase_in  = PHASE_INT;
            sec_in    = '0;
            run_in    = '0;
            colons_in = '0;
            frac_in   = '0;
            fdig_in   = '0;
         end else if (in_play) begin
            priority if (is_digit && phase_ff == PHASE_INT) begin
               if (run_ovf) begin
                  phase_in = PHASE_ERR;
               end else begin
                  run_in = run_x10[W-2:0];
               end
            end else if (is_digit) begin
               if (fdig_ff == 2'd3) begin
                  phase_in = PHASE_ERR;
               end else begin
                  frac_in = frac_x10;
                  fdig_in = fdig_ff + 2'd1;
               end
            end else if (phase_ff == PHASE_FRAC) begin
               phase_in = PHASE_ERR;
            end else if (char_code == tsp_pkg::CHAR_MINUS && first_ff) begin
               neg_in = 1'b1;
            end else if (char_code == tsp_pkg::CHAR_COLON) begin
               if (colons_ff == 2'd2 || fold_ovf || sec60_ovf) begin
                  phase_in = PHASE_ERR;
               end else begin
                  colons_in = colons_ff + 2'd1;
                  sec_in    = sec_x60[W-2:0];
                  run_in    = '0;
               end
            end else if (char_code == tsp_pkg::CHAR_DOT) begin
               if (fold_ovf) begin
                  phase_in = PHASE_ERR;
               end else begin
                  phase_in = PHASE_FRAC;
                  sec_in   = fold_sum[W-2:0];
                  run_in   = '0;
               end
            end else begin
               phase_in = PHASE_ERR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff       <= 1'b1;
         neg_ff         <= 1'b0;
         phase_ff       <= PHASE_INT;
         sec_ff         <= '0;
         run_ff         <= '0;
         colons_ff      <= '0;
         frac_ff        <= '0;
         fdig_ff        <= '0;
         total_ff.valid <= 1'b0;
      end else begin
         first_ff       <= first_in;
         neg_ff         <= neg_in;
         phase_ff       <= phase_in;
         sec_ff         <= sec_in;
         run_ff         <= run_in;
         colons_ff      <= colons_in;
         frac_ff        <= frac_in;
         fdig_ff        <= fdig_in;
         total_ff.valid <= total_in.valid;
      end
      total_ff.ok          <= total_in.ok;
      total_ff.negative    <= total_in.negative;
      total_ff.fraction_ms <= total_in.fraction_ms;
      tsec_ff              <= tsec_in;
   end

   assign total         = total_ff;
   assign total_seconds = tsec_ff;

endmodule

[rtl/tsp_scale.sv]
module tsp_scale #(
   parameter int SECONDS_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsp_pkg::tsp_total_type    total,
   input  logic [SECONDS_WIDTH-2:0]  total_seconds,
   output logic                      total_pop,
   tsp_stream_if.source              rsp_ch
);

   localparam int PW = (SECONDS_WIDTH + 9 > tsp_pkg::MS_WIDTH) ?
                       SECONDS_WIDTH + 9 : tsp_pkg::MS_WIDTH;

   logic                                out_v_ff, out_v_in;
   logic signed [tsp_pkg::MS_WIDTH-1:0] out_ms_ff, out_ms_in;
   logic                                out_ok_ff, out_ok_in;

   logic [PW-1:0]                 sec_ext;
   logic [PW-1:0]                 ms_abs;
   logic [tsp_pkg::MS_WIDTH-1:0]  ms_signed;

   assign total_pop = total.valid && (!out_v_ff || rsp_ch.ready);

   // seconds * 1000 as (s << 10) - (s << 4) - (s << 3), plus the fraction
   assign sec_ext   = PW'(total_seconds);
   assign ms_abs    = (sec_ext << 10) - (sec_ext << 4) - (sec_ext << 3)
                    + PW'(total.fraction_ms);
   assign ms_signed = total.negative ? -ms_abs[tsp_pkg::MS_WIDTH-1:0]
                                     :  ms_abs[tsp_pkg::MS_WIDTH-1:0];

   always_comb begin
      out_v_in  = out_v_ff && !rsp_ch.ready;
      out_ms_in = out_ms_ff;
      out_ok_in = out_ok_ff;
      if (total_pop) begin
         out_v_in  = 1'b1;
         out_ok_in = total.ok;
         out_ms_in = total.ok ? ms_signed : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      out_ms_ff <= out_ms_in;
      out_ok_ff <= out_ok_in;
   end

   assign rsp_ch.valid             = out_v_ff;
   assign rsp_ch.payload.time_ms   = out_ms_ff;
   assign rsp_ch.payload.valid_res = out_ok_ff;

endmodule

[rtl/time_string_parser_unit.sv]
// Time string parser: hours:minutes:seconds.fraction text to signed milliseconds.
//
// req_ch carries one character beat per cycle while ready is high; code 0 ends
// the string. rsp_ch carries one beat per terminator: time_ms (42-bit two's
// complement) and valid_res; a malformed string gives time_ms = 0, valid_res = 0.
//
// Throughput is one character per cycle while no terminator waits for the
// totals slot; the scanner updates its parse state as it takes each character.
// A terminator passes the input register, the scanner totals register, then
// the millisecond scaling into the output register, where rsp_ch goes valid.
//
// Synchronous reset empties every stage and clears the parse state, ready for a
// new string. When rsp_ch stalls, the finished response holds in the output
// register and a second terminator holds in the totals stage; characters keep
// flowing until a third terminator reaches the input register, where it waits
// and drops req_ch.ready.
module time_string_parser_unit #(
   parameter int SECONDS_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   tsp_stream_if.sink   req_ch,
   tsp_stream_if.source rsp_ch
);

   logic       in_v_ff, in_v_in;
   logic [7:0] in_char_ff, in_char_in;

   logic                         char_take;
   logic                         total_pop;
   tsp_pkg::tsp_total_type       total;
   logic [SECONDS_WIDTH-2:0]     total_seconds;

   assign req_ch.ready = !in_v_ff || char_take;

   always_comb begin
      in_v_in    = in_v_ff && !char_take;
      in_char_in = in_char_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_v_in    = 1'b1;
         in_char_in = req_ch.payload.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      in_char_ff <= in_char_in;
   end

   tsp_scan #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .char_valid    (in_v_ff),
      .char_code     (in_char_ff),
      .char_take     (char_take),
      .total_pop     (total_pop),
      .total         (total),
      .total_seconds (total_seconds)
   );

   tsp_scale #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_scale (
      .clock         (clock),
      .reset         (reset),
      .total         (total),
      .total_seconds (total_seconds),
      .total_pop     (total_pop),
      .rsp_ch        (rsp_ch)
   );

   // only a waiting beat can block the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_v_ff)
      else $error("input blocked with an empty input register");

   a_plain_char_flows: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && in_char_ff != tsp_pkg::CHAR_NUL |-> char_take)
      else $error("non-terminator character stalled");

   a_total_holds: assert property (@(posedge clock) disable iff (reset)
      total.valid && !total_pop |=> total.valid)
      else $error("string totals lost while the output was busy");

   a_term_holds: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !char_take |=> in_v_ff && in_char_ff == tsp_pkg::CHAR_NUL)
      else $error("stalled terminator dropped");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.payload.valid_res |-> rsp_ch.payload.time_ms == '0)
      else $error("invalid response with nonzero time");

endmodule

[tb/tb_time_string_parser_unit.sv]
`timescale 1ns / 1ps

module tb_time_string_parser_unit;

   localparam int SEC_W = 32;
   localparam logic [63:0] SEC_LIMIT = (64'd1 << (SEC_W - 1)) - 64'd1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_CHAR_TARGET = 700;
   localparam int NOISE_CHAR_TARGET = 850;

   typedef enum logic [1:0] {
      SCAN_WHOLE    = 2'd0,
      SCAN_FRACTION = 2'd1,
      SCAN_FAULT    = 2'd2
   } scan_phase_type;

   logic clock;
   logic reset;

   tsp_stream_if #(.payload_type(tsp_pkg::tsp_req_type)) req_if ();
   tsp_stream_if #(.payload_type(tsp_pkg::tsp_rsp_type)) rsp_if ();

   time_string_parser_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // parse state of the string in flight
   logic           scan_first;
   logic           scan_negative;
   scan_phase_type scan_phase;
   logic [63:0]    scan_seconds;
   logic [63:0]    scan_run;
   logic [1:0]     scan_colons;
   logic [9:0]     scan_frac;
   logic [2:0]     scan_frac_digits;

   tsp_pkg::tsp_rsp_type expected_times[$];

   int fail_count = 0;
   int chars_sent = 0;
   int strings_sent = 0;
   int valid_seen = 0;
   int invalid_seen = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   function automatic void clear_scan();
      scan_first       = 1'b1;
      scan_negative    = 1'b0;
      scan_phase       = SCAN_WHOLE;
      scan_seconds     = '0;
      scan_run         = '0;
      scan_colons      = '0;
      scan_frac        = '0;
      scan_frac_digits = '0;
   endfunction

   // Add the pending digit run to the seconds sum; leave both alone on overflow.
   function automatic logic fold_pending_run();
      if (scan_run > SEC_LIMIT - scan_seconds) return 1'b0;
      scan_seconds = scan_seconds + scan_run;
      scan_run     = '0;
      return 1'b1;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      logic                 was_first;
      logic                 ok;
      logic [3:0]           d;
      logic [9:0]           f;
      logic [63:0]          ms;
      tsp_pkg::tsp_rsp_type want;
      was_first  = scan_first;
      scan_first = 1'b0;

      if (c == tsp_pkg::CHAR_NUL) begin
         ms = '0;
         ok = 1'b0;
         if (scan_phase == SCAN_WHOLE || scan_phase == SCAN_FRACTION) ok = fold_pending_run();
         if (ok) begin
            f = scan_frac;
            if (scan_frac_digits == 3'd1) f = scan_frac * 10'd100;
            else if (scan_frac_digits == 3'd2) f = scan_frac * 10'd10;
            ms = scan_seconds * 64'd1000 + 64'(f);
            if (scan_negative) ms = -ms;
         end
         want.time_ms   = ms[tsp_pkg::MS_WIDTH-1:0];
         want.valid_res = ok;
         expected_times.push_back(want);
         clear_scan();
         return;
      end

      if (scan_phase != SCAN_WHOLE && scan_phase != SCAN_FRACTION) return;

      if (c >= tsp_pkg::CHAR_ZERO && c <= tsp_pkg::CHAR_NINE) begin
         d = 4'(c - tsp_pkg::CHAR_ZERO);
         if (scan_phase == SCAN_WHOLE) begin
            if (scan_run > (SEC_LIMIT - 64'(d)) / 64'd10) scan_phase = SCAN_FAULT;
            else scan_run = scan_run * 64'd10 + 64'(d);
         end else begin
            if (scan_frac_digits >= 3'd3) begin
               scan_phase = SCAN_FAULT;
            end else begin
               scan_frac        = scan_frac * 10'd10 + 10'(d);
               scan_frac_digits = scan_frac_digits + 3'd1;
            end
         end
         return;
      end

      if (scan_phase == SCAN_FRACTION) begin
         scan_phase = SCAN_FAULT;
         return;
      end

      if (c == tsp_pkg::CHAR_MINUS && was_first) begin
         scan_negative = 1'b1;
      end else if (c == tsp_pkg::CHAR_COLON) begin
         if (scan_colons >= 2'd2) scan_phase = SCAN_FAULT;
         else if (!fold_pending_run()) scan_phase = SCAN_FAULT;
         else if (scan_seconds > SEC_LIMIT / 64'd60) scan_phase = SCAN_FAULT;
         else begin
            scan_colons  = scan_colons + 2'd1;
            scan_seconds = scan_seconds * 64'd60;
         end
      end else if (c == tsp_pkg::CHAR_DOT) begin
         if (!fold_pending_run()) scan_phase = SCAN_FAULT;
         else scan_phase = SCAN_FRACTION;
      end else begin
         scan_phase = SCAN_FAULT;
      end
   endfunction

   // Send one character beat; idle between bursts.
   task automatic send_char(input logic [7:0] c);
      tsp_pkg::tsp_req_type beat;
      beat.char_code = c;
      req_if.valid   <= 1'b1;
      req_if.payload <= beat;
      do @(posedge clock); while (!req_if.ready);
      parse_char(c);
      chars_sent++;
      if (c == tsp_pkg::CHAR_NUL) strings_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(0, 12);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(tsp_pkg::CHAR_NUL);
   endtask

   task automatic test_directed_strings();
      string cases[$];
      cases = '{"", "-", "0", "12", "1:02:03.456", "-1:00", "::", ":5", "12.", "12.5",
                "12.05", "0.999", ".5", "1.2345", "1:2:3:4", "2147483647",
                "2147483648", "2147483647.999", "-2147483647.999", "596523:14:07",
                "35791395:", "35791394:8", "1a2", "1.2x", "1.:3", "1..", "5-3", "--1"};
      foreach (cases[i]) send_text(cases[i]);
   endtask

   task automatic test_odd_bytes();
      send_char(8'hFF);
      send_char(tsp_pkg::CHAR_NUL);
      send_char(tsp_pkg::CHAR_MINUS);
      send_char(8'h80);
      send_char(tsp_pkg::CHAR_NUL);
      send_char(tsp_pkg::CHAR_ZERO);
      send_char(8'h7F);
      send_char(tsp_pkg::CHAR_NINE);
      send_char(tsp_pkg::CHAR_NUL);
   endtask

   // Mostly well-formed strings with random digits; a few get broken on purpose.
   task automatic test_random_strings(input int char_target);
      logic [7:0] text[$];
      int groups;
      int digits;
      int flavor;
      int pos;
      while (chars_sent < char_target) begin
         text.delete();
         flavor = $urandom_range(0, 9);
         if ($urandom_range(0, 3) == 0) text.push_back(tsp_pkg::CHAR_MINUS);
         groups = $urandom_range(1, 3);
         for (int g = 0; g < groups; g++) begin
            if (g > 0) text.push_back(tsp_pkg::CHAR_COLON);
            digits = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 2);
            for (int k = 0; k < digits; k++)
               text.push_back(8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) begin
            text.push_back(tsp_pkg::CHAR_DOT);
            digits = $urandom_range(0, 3);
            for (int k = 0; k < digits; k++)
               text.push_back(8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         end
         case (flavor)
            0: begin
               pos = $urandom_range(0, text.size());
               if (pos == text.size()) text.push_back(8'($urandom_range(1, 255)));
               else text[pos] = 8'($urandom_range(1, 255));
            end
            1: begin
               text.push_back(tsp_pkg::CHAR_COLON);
               text.push_back(8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
            2: text.push_back(8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            default: ;
         endcase
         foreach (text[i]) send_char(text[i]);
         send_char(tsp_pkg::CHAR_NUL);
      end
   endtask

   // Short runs of arbitrary bytes, mixed with format characters.
   task automatic test_noise_strings(input int char_target);
      int run;
      logic [7:0] pick;
      while (chars_sent < char_target) begin
         run = $urandom_range(1, 10);
         for (int k = 0; k < run; k++) begin
            case ($urandom_range(0, 3))
               0: pick = tsp_pkg::CHAR_COLON;
               1: pick = 8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9));
               default: pick = 8'($urandom_range(1, 255));
            endcase
            send_char(pick);
         end
         send_char(tsp_pkg::CHAR_NUL);
      end
   endtask

   // Check each response beat and drive the receiver's stall pattern.
   int ready_mode = 0;
   int ready_left = 0;
   int ready_period = 2;
   int ready_duty = 1;
   int ready_pos = 0;
   always @(posedge clock) begin
      tsp_pkg::tsp_rsp_type got;
      tsp_pkg::tsp_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (got.valid_res === 1'b1) valid_seen++;
         else invalid_seen++;
         if (expected_times.size() == 0) begin
            report_mismatch($sformatf("unexpected result time_ms=%0d valid_res=%b",
                                      got.time_ms, got.valid_res));
         end else begin
            want = expected_times.pop_front();
            if (got.time_ms !== want.time_ms)
               report_mismatch($sformatf("time_ms got %0d expected %0d",
                                         got.time_ms, want.time_ms));
            if (got.valid_res !== want.valid_res)
               report_mismatch($sformatf("valid_res got %b expected %b",
                                         got.valid_res, want.valid_res));
         end
      end
      if (ready_left == 0) begin
         ready_mode   = $urandom_range(0, 2);
         ready_left   = $urandom_range(20, 120);
         ready_period = $urandom_range(2, 9);
         ready_duty   = $urandom_range(1, ready_period - 1);
         ready_pos    = 0;
      end
      ready_left--;
      ready_pos++;
      case (ready_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ((ready_pos % ready_period) < ready_duty);
         default: rsp_if.ready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_times.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      clear_scan();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_odd_bytes();
      test_random_strings(RANDOM_CHAR_TARGET);
      test_noise_strings(NOISE_CHAR_TARGET);

      req_if.valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d characters in %0d strings: directed formats, random times, noise",
               chars_sent, strings_sent);
      $display("Results: %0d parsed as valid, %0d rejected, %0d mismatches",
               valid_seen, invalid_seen, fail_count);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
